/* rtl/i2cm_pkg.sv */
// shared types and constants for the i2c master controller
// command codes, the queued tick record and the queue sizing; no dependencies
package i2cm_pkg;

    localparam int DELAY_W     = 16;
    localparam int ADDR_W      = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd250;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_START       = 3'd1,
        CMD_STOP        = 3'd2,
        CMD_WRITE       = 3'd3,
        CMD_READ_ACK    = 3'd4,
        CMD_READ_NACK   = 3'd5,
        CMD_RANDOM_READ = 3'd6
    } cmd_t;

    // one tick after classification
    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr_hold;
        logic              sda;
    } item_t;

    // head of the queue as seen by the bus engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

/* rtl/i2c_master_controller_core.sv */
// top level of the tick driven i2c master controller: apb register, front end,
// queue and bus engine; depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_engine
//
//  channel   direction  handshake              contents
//  s_*       in         s_valid / s_ready      command, operands, sda sample (one tick)
//  m_*       out        m_valid / m_ready      scl/sda drive, ready, done, read data, nack
//  apb       in/out     psel, penable, pwrite  delay_ticks at byte address 0
//
//  one tick per cycle sustained while m_ready stays high; an accepted tick is written
//  into the queue and then into the engine output register, which drives m_*
//  the per-tick sequencer update is combinational logic in the engine
//  reset is synchronous on aresetn: bus released, sequencer idle, delay_ticks 250
//  the two-entry queue keeps taking ticks while m_ready is low, then s_ready drops
//  a tick with no command or code 7 just advances the running phase timer
module i2c_master_controller_core (
    input  logic        aclk,
    input  logic        aresetn,

    // tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_write_byte,
    input  logic [7:0]  s_device_address,
    input  logic [15:0] s_register_address,
    input  logic        s_sda_in,

    // tick result
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_level,
    output logic        m_ready_res,
    output logic        m_done_res,
    output logic [7:0]  m_read_data,
    output logic        m_nack,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cm_pkg::*;

    localparam logic REG_DELAY = 1'b0;

    logic [DELAY_W-1:0] delay_reg;
    logic               cfg_write;
    item_t              front_item;
    head_t              q_head;
    logic               q_pop;
    logic               q_not_full;

    // register file: one word, index taken from paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DELAY) ? {16'b0, delay_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= DELAY_RESET;
        end else if (cfg_write && paddr[2] == REG_DELAY) begin
            delay_reg <= pwdata[DELAY_W-1:0];
        end
    end

    // front end: command classification
    i2cm_front u_front (
        .s_command          (s_command),
        .s_write_byte       (s_write_byte),
        .s_device_address   (s_device_address),
        .s_register_address (s_register_address),
        .s_sda_in           (s_sda_in),
        .item               (front_item)
    );

    // decoupling queue; full queue backpressures the input transaction
    i2cm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    assign s_ready = q_not_full;

    // back end: phase sequencer and result register
    i2cm_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .delay_ticks (delay_reg),
        .head        (q_head),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_level (m_scl_level),
        .m_sda_level (m_sda_level),
        .m_ready_res (m_ready_res),
        .m_done_res  (m_done_res),
        .m_read_data (m_read_data),
        .m_nack      (m_nack)
    );

endmodule

/* rtl/i2cm_front.sv */
// front end: classifies the command of each incoming tick and packs its operands
// depends on i2cm_pkg
module i2cm_front (
    input  logic [2:0]        s_command,
    input  logic [7:0]        s_write_byte,
    input  logic [7:0]        s_device_address,
    input  logic [15:0]       s_register_address,
    input  logic              s_sda_in,
    output i2cm_pkg::item_t   item
);
    import i2cm_pkg::*;

    always_comb begin
        item.sda = s_sda_in;
        unique case (s_command) inside
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK,
            CMD_RANDOM_READ: begin
                item.cmd = cmd_t'(s_command);
            end
            default: begin
                item.cmd = CMD_NONE;
            end
        endcase
        // random read carries device and register address, the rest the write byte
        if (item.cmd == CMD_RANDOM_READ) begin
            item.addr_hold = {s_device_address, s_register_address};
        end else begin
            item.addr_hold = {16'b0, s_write_byte};
        end
    end

endmodule

/* rtl/i2cm_queue.sv */
// short fifo between the front end and the bus engine
// depends on i2cm_pkg
module i2cm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  i2cm_pkg::item_t   push_item,
    output logic              not_full,
    input  logic              pop,
    output i2cm_pkg::head_t   head
);
    import i2cm_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign not_full   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push && not_full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue fill count lost a push");

endmodule

/* rtl/i2cm_engine.sv */
// bus engine: advances the i2c phase sequencer by one tick per queued item
// and holds the result in an output register; depends on i2cm_pkg
module i2cm_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [i2cm_pkg::DELAY_W-1:0]  delay_ticks,
    input  i2cm_pkg::head_t               head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_scl_level,
    output logic                          m_sda_level,
    output logic                          m_ready_res,
    output logic                          m_done_res,
    output logic [7:0]                    m_read_data,
    output logic                          m_nack
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_START_A = 5'd1,
        PH_START_B = 5'd2,
        PH_START_C = 5'd3,
        PH_STOP_A  = 5'd4,
        PH_STOP_B  = 5'd5,
        PH_STOP_C  = 5'd6,
        PH_STOP_D  = 5'd7,
        PH_WR_A    = 5'd8,
        PH_WR_B    = 5'd9,
        PH_WR_C    = 5'd10,
        PH_ACK_A   = 5'd11,
        PH_ACK_B   = 5'd12,
        PH_ACK_C   = 5'd13,
        PH_RD_A    = 5'd14,
        PH_RD_B    = 5'd15,
        PH_RA_A    = 5'd16,
        PH_RA_B    = 5'd17,
        PH_RA_C    = 5'd18,
        PH_RA_D    = 5'd19
    } phase_t;

    typedef enum logic [3:0] {
        P_END       = 4'd0,
        P_START     = 4'd1,
        P_STOP      = 4'd2,
        P_SEND_LOW  = 4'd3,
        P_SEND_DEV  = 4'd4,
        P_SEND_HI   = 4'd5,
        P_SEND_DEVR = 4'd6,
        P_WACK_REC  = 4'd7,
        P_WACK_CHK  = 4'd8,
        P_WACK_IGN  = 4'd9,
        P_RECV      = 4'd10,
        P_ACK       = 4'd11,
        P_NACK      = 4'd12
    } prim_t;

    typedef struct packed {
        phase_t     ph;
        logic [7:0] sh;
        logic       done;
    } begin_t;

    localparam int RR_LEN = 13;
    localparam logic [3:0] STOP_INDEX = 4'd12;
    localparam prim_t RR_SEQ [RR_LEN] = '{
        P_START, P_SEND_DEV, P_WACK_CHK, P_SEND_HI, P_WACK_IGN, P_SEND_LOW,
        P_WACK_IGN, P_START, P_SEND_DEVR, P_WACK_IGN, P_RECV, P_NACK, P_STOP
    };

    function automatic prim_t prim_at(cmd_t c, logic [3:0] s);
        prim_t r;
        r = P_END;
        case (c)
            CMD_START:       r = (s == 4'd0) ? P_START : P_END;
            CMD_STOP:        r = (s == 4'd0) ? P_STOP : P_END;
            CMD_WRITE:       r = (s == 4'd0) ? P_SEND_LOW : (s == 4'd1) ? P_WACK_REC : P_END;
            CMD_READ_ACK:    r = (s == 4'd0) ? P_RECV : (s == 4'd1) ? P_ACK : P_END;
            CMD_READ_NACK:   r = (s == 4'd0) ? P_RECV : (s == 4'd1) ? P_NACK : P_END;
            CMD_RANDOM_READ: r = (s < 4'(RR_LEN)) ? RR_SEQ[s] : P_END;
            default:         r = P_END;
        endcase
        return r;
    endfunction

    function automatic begin_t begin_prim(prim_t p, logic [ADDR_W-1:0] a, logic [7:0] sh);
        begin_t r;
        r.ph   = PH_IDLE;
        r.sh   = sh;
        r.done = 1'b0;
        case (p) inside
            P_START:     r.ph = PH_START_A;
            P_STOP:      r.ph = PH_STOP_A;
            P_SEND_LOW: begin
                r.sh = a[7:0];
                r.ph = PH_WR_A;
            end
            P_SEND_HI: begin
                r.sh = a[15:8];
                r.ph = PH_WR_A;
            end
            P_SEND_DEV: begin
                r.sh = a[23:16];
                r.ph = PH_WR_A;
            end
            P_SEND_DEVR: begin
                r.sh = {a[23:17], 1'b1};
                r.ph = PH_WR_A;
            end
            P_WACK_REC, P_WACK_CHK, P_WACK_IGN: r.ph = PH_ACK_A;
            P_RECV: begin
                r.sh = 8'h00;
                r.ph = PH_RD_A;
            end
            P_ACK, P_NACK: r.ph = PH_RA_A;
            default: begin
                r.ph   = PH_IDLE;
                r.done = 1'b1;
            end
        endcase
        return r;
    endfunction

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [3:0]         step_reg, step_next;
    logic [3:0]         bit_count_reg, bit_count_next;
    logic [7:0]         shift_reg, shift_next;
    logic [DELAY_W-1:0] timer_reg, timer_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               ack_reg, ack_next;
    cmd_t               run_cmd_reg, run_cmd_next;
    logic [7:0]         rx_reg, rx_next;
    logic               done_next;

    // output register
    logic               m_valid_reg;
    logic               m_done_reg;
    logic               m_ready_res_reg;

    logic [DELAY_W-1:0] eff_delay;
    logic [DELAY_W-1:0] timer_inc;

    assign eff_delay = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
    assign pop       = head.valid && (!m_valid_reg || m_ready);

    always_comb begin
        begin_t b;
        prim_t  p;
        phase_t ph_cur;
        logic   adv;
        logic   jump_stop;

        phase_next     = phase_reg;
        step_next      = step_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        timer_next     = timer_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        addr_next      = addr_reg;
        ack_next       = ack_reg;
        run_cmd_next   = run_cmd_reg;
        rx_next        = rx_reg;
        done_next      = 1'b0;
        adv            = 1'b0;
        jump_stop      = 1'b0;
        timer_inc      = '0;
        b              = '0;
        p              = P_END;
        ph_cur         = PH_IDLE;

        // command launch while idle
        if (phase_reg == PH_IDLE && head.item.cmd != CMD_NONE) begin
            run_cmd_next   = head.item.cmd;
            step_next      = 4'd0;
            ack_next       = 1'b0;
            addr_next      = head.item.addr_hold;
            timer_next     = '0;
            bit_count_next = 4'd0;
            b              = begin_prim(prim_at(head.item.cmd, 4'd0), addr_next, shift_next);
            phase_next     = b.ph;
            shift_next     = b.sh;
            done_next      = done_next | b.done;
        end

        if (phase_next != PH_IDLE) begin
            p = prim_at(run_cmd_next, step_next);
            // first tick of a phase drives its levels
            if (timer_next == '0) begin
                unique case (phase_next)
                    PH_START_A: begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    PH_START_B: sda_next = 1'b0;
                    PH_START_C: scl_next = 1'b0;
                    PH_STOP_B:  sda_next = 1'b0;
                    PH_STOP_C:  scl_next = 1'b1;
                    PH_STOP_D:  sda_next = 1'b1;
                    PH_WR_A:    sda_next = shift_next[7];
                    PH_WR_B:    scl_next = 1'b1;
                    PH_WR_C:    scl_next = 1'b0;
                    PH_ACK_A:   sda_next = 1'b1;
                    PH_ACK_B:   scl_next = 1'b1;
                    PH_ACK_C:   scl_next = 1'b0;
                    PH_RD_A: begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    PH_RD_B:    scl_next = 1'b1;
                    PH_RA_A:    scl_next = 1'b0;
                    PH_RA_B:    sda_next = (p == P_NACK);
                    PH_RA_C:    scl_next = 1'b1;
                    PH_RA_D:    scl_next = 1'b0;
                    default:    ;
                endcase
            end

            timer_inc = timer_next + DELAY_W'(1);
            if (timer_inc >= eff_delay) begin
                timer_next = '0;
                ph_cur     = phase_next;
                unique case (ph_cur)
                    PH_START_A: phase_next = PH_START_B;
                    PH_START_B: phase_next = PH_START_C;
                    PH_STOP_A:  phase_next = PH_STOP_B;
                    PH_STOP_B:  phase_next = PH_STOP_C;
                    PH_STOP_C:  phase_next = PH_STOP_D;
                    PH_WR_A:    phase_next = PH_WR_B;
                    PH_WR_B:    phase_next = PH_WR_C;
                    PH_WR_C: begin
                        shift_next     = {shift_next[6:0], 1'b0};
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next < 4'd8) begin
                            phase_next = PH_WR_A;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    PH_ACK_A:   phase_next = PH_ACK_B;
                    PH_ACK_B: begin
                        if (p != P_WACK_IGN) begin
                            ack_next = head.item.sda;
                        end
                        if (head.item.sda) begin
                            // missing device acknowledge aborts into a stop
                            if (p == P_WACK_CHK) begin
                                jump_stop = 1'b1;
                            end else begin
                                adv = 1'b1;
                            end
                        end else begin
                            phase_next = PH_ACK_C;
                        end
                    end
                    PH_RD_A:    phase_next = PH_RD_B;
                    PH_RD_B: begin
                        shift_next     = {shift_next[6:0], head.item.sda};
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next < 4'd8) begin
                            phase_next = PH_RD_A;
                        end else begin
                            rx_next = shift_next;
                            adv     = 1'b1;
                        end
                    end
                    PH_RA_A:    phase_next = PH_RA_B;
                    PH_RA_B:    phase_next = PH_RA_C;
                    PH_RA_C:    phase_next = PH_RA_D;
                    PH_START_C, PH_STOP_D, PH_ACK_C, PH_RA_D: adv = 1'b1;
                    default:    phase_next = PH_IDLE;
                endcase

                if (adv || jump_stop) begin
                    if (jump_stop) begin
                        step_next = STOP_INDEX;
                        b = begin_prim(P_STOP, addr_next, shift_next);
                    end else begin
                        step_next = step_next + 4'd1;
                        b = begin_prim(prim_at(run_cmd_next, step_next), addr_next, shift_next);
                    end
                    bit_count_next = 4'd0;
                    phase_next     = b.ph;
                    shift_next     = b.sh;
                    done_next      = done_next | b.done;
                end
            end else begin
                timer_next = timer_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            step_reg        <= 4'd0;
            bit_count_reg   <= 4'd0;
            shift_reg       <= 8'h00;
            timer_reg       <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            addr_reg        <= '0;
            ack_reg         <= 1'b0;
            run_cmd_reg     <= CMD_NONE;
            rx_reg          <= 8'h00;
            m_valid_reg     <= 1'b0;
            m_done_reg      <= 1'b0;
            m_ready_res_reg <= 1'b1;
        end else begin
            if (pop) begin
                phase_reg       <= phase_next;
                step_reg        <= step_next;
                bit_count_reg   <= bit_count_next;
                shift_reg       <= shift_next;
                timer_reg       <= timer_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                addr_reg        <= addr_next;
                ack_reg         <= ack_next;
                run_cmd_reg     <= run_cmd_next;
                rx_reg          <= rx_next;
                m_done_reg      <= done_next;
                m_ready_res_reg <= (phase_next == PH_IDLE);
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_level = scl_reg;
    assign m_sda_level = sda_reg;
    assign m_ready_res = m_ready_res_reg;
    assign m_done_res  = m_done_reg;
    assign m_read_data = rx_reg;
    assign m_nack      = ack_reg;

    a_busy_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (run_cmd_reg != CMD_NONE))
        else $error("sequencer busy without a running command");

    a_bit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= 4'd8)
        else $error("bit counter past one byte");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> m_ready_res_reg)
        else $error("done reported while sequencer still busy");

endmodule

/* test/i2c_tick_checker.sv */
// result checker for the tick driven i2c master controller: tracks the apb delay
// register, predicts the bus levels of every accepted tick and compares results
// depends on i2cm_pkg for the command codes
module i2c_tick_checker #(
    parameter logic [2:0] DELAY_ADDR = 3'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_write_byte,
    input  logic [7:0]  s_device_address,
    input  logic [15:0] s_register_address,
    input  logic        s_sda_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_scl_level,
    input  logic        m_sda_level,
    input  logic        m_ready_res,
    input  logic        m_done_res,
    input  logic [7:0]  m_read_data,
    input  logic        m_nack,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding,
    output int          compared
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        BP_IDLE, BP_START_1, BP_START_2, BP_START_3,
        BP_STOP_1, BP_STOP_2, BP_STOP_3, BP_STOP_4,
        BP_TX_DATA, BP_TX_HIGH, BP_TX_LOW,
        BP_ACK_REL, BP_ACK_HIGH, BP_ACK_LOW,
        BP_RX_LOW, BP_RX_HIGH,
        BP_REPLY_LOW, BP_REPLY_DRIVE, BP_REPLY_HIGH, BP_REPLY_END
    } bus_phase_t;

    typedef enum logic [3:0] {
        OP_DONE, OP_START, OP_STOP, OP_TX_LOW, OP_TX_DEV, OP_TX_HIGH, OP_TX_DEV_RD,
        OP_ACK_KEEP, OP_ACK_CHECK, OP_ACK_SKIP, OP_RX, OP_REPLY_ACK, OP_REPLY_NACK
    } bus_op_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       idle;
        logic       done;
        logic [7:0] rdata;
        logic       nack;
    } bus_sample_t;

    // the random read jumps here when the device does not acknowledge
    localparam logic [3:0] ABORT_STEP = 4'd12;

    bus_sample_t  expected_q[$];
    bus_sample_t  want;

    logic [15:0]  delay;
    bus_phase_t   ph;
    cmd_t         run;
    logic [3:0]   step;
    logic [3:0]   bits_done;
    logic [7:0]   shreg;
    logic [15:0]  tmr;
    logic         scl_q;
    logic         sda_q;
    logic [23:0]  addr;
    logic         ack;
    logic [7:0]   rx;
    logic         done_flag;

    function automatic bus_op_t op_at(cmd_t c, logic [3:0] s);
        case (c)
            CMD_START: return (s == 4'd0) ? OP_START : OP_DONE;
            CMD_STOP: return (s == 4'd0) ? OP_STOP : OP_DONE;
            CMD_WRITE: return (s == 4'd0) ? OP_TX_LOW : (s == 4'd1) ? OP_ACK_KEEP : OP_DONE;
            CMD_READ_ACK: return (s == 4'd0) ? OP_RX : (s == 4'd1) ? OP_REPLY_ACK : OP_DONE;
            CMD_READ_NACK: return (s == 4'd0) ? OP_RX : (s == 4'd1) ? OP_REPLY_NACK : OP_DONE;
            CMD_RANDOM_READ: begin
                case (s)
                    4'd0: return OP_START;
                    4'd1: return OP_TX_DEV;
                    4'd2: return OP_ACK_CHECK;
                    4'd3: return OP_TX_HIGH;
                    4'd4: return OP_ACK_SKIP;
                    4'd5: return OP_TX_LOW;
                    4'd6: return OP_ACK_SKIP;
                    4'd7: return OP_START;
                    4'd8: return OP_TX_DEV_RD;
                    4'd9: return OP_ACK_SKIP;
                    4'd10: return OP_RX;
                    4'd11: return OP_REPLY_NACK;
                    4'd12: return OP_STOP;
                    default: return OP_DONE;
                endcase
            end
            default: return OP_DONE;
        endcase
    endfunction

    function automatic void begin_op(bus_op_t p);
        bits_done = 4'd0;
        case (p)
            OP_START: ph = BP_START_1;
            OP_STOP: ph = BP_STOP_1;
            OP_TX_LOW: begin
                shreg = addr[7:0];
                ph = BP_TX_DATA;
            end
            OP_TX_HIGH: begin
                shreg = addr[15:8];
                ph = BP_TX_DATA;
            end
            OP_TX_DEV: begin
                shreg = addr[23:16];
                ph = BP_TX_DATA;
            end
            OP_TX_DEV_RD: begin
                shreg = {addr[23:17], 1'b1};
                ph = BP_TX_DATA;
            end
            OP_ACK_KEEP, OP_ACK_CHECK, OP_ACK_SKIP: ph = BP_ACK_REL;
            OP_RX: begin
                shreg = 8'd0;
                ph = BP_RX_LOW;
            end
            OP_REPLY_ACK, OP_REPLY_NACK: ph = BP_REPLY_LOW;
            default: begin
                ph = BP_IDLE;
                done_flag = 1'b1;
            end
        endcase
    endfunction

    function automatic void next_op();
        step = step + 4'd1;
        begin_op(op_at(run, step));
    endfunction

    // levels are driven on the first tick of each phase
    function automatic void drive_levels();
        case (ph)
            BP_START_1: begin
                scl_q = 1'b1;
                sda_q = 1'b1;
            end
            BP_START_2: sda_q = 1'b0;
            BP_START_3: scl_q = 1'b0;
            BP_STOP_2: sda_q = 1'b0;
            BP_STOP_3: scl_q = 1'b1;
            BP_STOP_4: sda_q = 1'b1;
            BP_TX_DATA: sda_q = shreg[7];
            BP_TX_HIGH: scl_q = 1'b1;
            BP_TX_LOW: scl_q = 1'b0;
            BP_ACK_REL: sda_q = 1'b1;
            BP_ACK_HIGH: scl_q = 1'b1;
            BP_ACK_LOW: scl_q = 1'b0;
            BP_RX_LOW: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
            end
            BP_RX_HIGH: scl_q = 1'b1;
            BP_REPLY_LOW: scl_q = 1'b0;
            BP_REPLY_DRIVE: sda_q = (op_at(run, step) == OP_REPLY_NACK);
            BP_REPLY_HIGH: scl_q = 1'b1;
            BP_REPLY_END: scl_q = 1'b0;
            default: ;
        endcase
    endfunction

    // last tick of a phase: sample sda where it matters and move on
    function automatic void finish_phase(logic sda_s);
        bus_op_t p;
        case (ph)
            BP_START_1: ph = BP_START_2;
            BP_START_2: ph = BP_START_3;
            BP_STOP_1: ph = BP_STOP_2;
            BP_STOP_2: ph = BP_STOP_3;
            BP_STOP_3: ph = BP_STOP_4;
            BP_TX_DATA: ph = BP_TX_HIGH;
            BP_TX_HIGH: ph = BP_TX_LOW;
            BP_TX_LOW: begin
                shreg = {shreg[6:0], 1'b0};
                bits_done = bits_done + 4'd1;
                if (bits_done < 4'd8) ph = BP_TX_DATA;
                else next_op();
            end
            BP_ACK_REL: ph = BP_ACK_HIGH;
            BP_ACK_HIGH: begin
                p = op_at(run, step);
                if (p != OP_ACK_SKIP) ack = sda_s;
                if (sda_s) begin
                    // no acknowledge: scl stays high, low half of the slot skipped
                    if (p == OP_ACK_CHECK) begin
                        step = ABORT_STEP;
                        begin_op(OP_STOP);
                    end else begin
                        next_op();
                    end
                end else begin
                    ph = BP_ACK_LOW;
                end
            end
            BP_RX_LOW: ph = BP_RX_HIGH;
            BP_RX_HIGH: begin
                shreg = {shreg[6:0], sda_s};
                bits_done = bits_done + 4'd1;
                if (bits_done < 4'd8) begin
                    ph = BP_RX_LOW;
                end else begin
                    rx = shreg;
                    next_op();
                end
            end
            BP_REPLY_LOW: ph = BP_REPLY_DRIVE;
            BP_REPLY_DRIVE: ph = BP_REPLY_HIGH;
            BP_REPLY_HIGH: ph = BP_REPLY_END;
            BP_START_3, BP_STOP_4, BP_ACK_LOW, BP_REPLY_END: next_op();
            default: ph = BP_IDLE;
        endcase
    endfunction

    function automatic bus_sample_t predict_tick(logic [2:0] c, logic [7:0] wb,
                                                 logic [7:0] dev, logic [15:0] ra,
                                                 logic sda_s);
        logic [15:0] span;
        bus_sample_t r;
        span = (delay == 16'd0) ? 16'd1 : delay;
        done_flag = 1'b0;
        if (ph == BP_IDLE && c >= CMD_START && c <= CMD_RANDOM_READ) begin
            run = cmd_t'(c);
            step = 4'd0;
            ack = 1'b0;
            addr = (run == CMD_RANDOM_READ) ? {dev, ra} : {16'd0, wb};
            tmr = 16'd0;
            begin_op(op_at(run, step));
        end
        if (ph != BP_IDLE) begin
            if (tmr == 16'd0) drive_levels();
            tmr = tmr + 16'd1;
            if (tmr >= span) begin
                tmr = 16'd0;
                finish_phase(sda_s);
            end
        end
        r.scl = scl_q;
        r.sda = sda_q;
        r.idle = (ph == BP_IDLE);
        r.done = done_flag;
        r.rdata = rx;
        r.nack = ack;
        return r;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        if (mismatches < 50)
            $display("%0t checker: %s expected %0d got %0d", $time, what, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            delay = DELAY_RESET;
            ph = BP_IDLE;
            run = CMD_NONE;
            step = 4'd0;
            bits_done = 4'd0;
            shreg = 8'd0;
            tmr = 16'd0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            addr = 24'd0;
            ack = 1'b0;
            rx = 8'd0;
            done_flag = 1'b0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, 1);
                end else begin
                    want = expected_q.pop_front();
                    compared++;
                    if (m_scl_level !== want.scl)
                        report_mismatch("scl_level", int'(want.scl), int'(m_scl_level));
                    if (m_sda_level !== want.sda)
                        report_mismatch("sda_level", int'(want.sda), int'(m_sda_level));
                    if (m_ready_res !== want.idle)
                        report_mismatch("ready_res", int'(want.idle), int'(m_ready_res));
                    if (m_done_res !== want.done)
                        report_mismatch("done_res", int'(want.done), int'(m_done_res));
                    if (m_read_data !== want.rdata)
                        report_mismatch("read_data", int'(want.rdata), int'(m_read_data));
                    if (m_nack !== want.nack)
                        report_mismatch("nack", int'(want.nack), int'(m_nack));
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_tick(s_command, s_write_byte, s_device_address,
                                                  s_register_address, s_sda_in));
            if (psel && penable && pready && paddr == DELAY_ADDR) begin
                if (pwrite)
                    delay = pwdata[15:0];
                else if (prdata[15:0] !== delay)
                    report_mismatch("delay_ticks readback", int'(delay), int'(prdata[15:0]));
            end
        end
        outstanding = expected_q.size();
    end

endmodule

/* test/i2c_master_controller_core_test.sv */
// testbench top for i2c_master_controller_core: clock, reset, tick stimulus,
// apb register traffic and receiver back-pressure; results are judged by
// i2c_tick_checker; depends on i2cm_pkg and the core rtl
module i2c_master_controller_core_test;
    import i2cm_pkg::*;

    localparam logic [2:0] REG_DELAY   = 3'd0;   // delay_ticks, register index 0
    localparam logic [2:0] REG_SPARE   = 3'd4;   // index 1: no register, writes dropped
    localparam logic [2:0] UNUSED_CMD  = 3'd7;   // code outside the command set
    localparam int         HOLD_CYCLES = 120;    // long receiver hold-off
    localparam int         LIMIT       = 300000; // cycle budget for the whole run

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [7:0]  s_write_byte;
    logic [7:0]  s_device_address;
    logic [15:0] s_register_address;
    logic        s_sda_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_scl_level;
    logic        m_sda_level;
    logic        m_ready_res;
    logic        m_done_res;
    logic [7:0]  m_read_data;
    logic        m_nack;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int compared;
    int cycles;
    int ticks_sent;
    int settings;
    int idle_pct;      // sender: chance of an empty cycle before a transaction
    int stall_pct;     // receiver: chance of m_ready low in a cycle
    int hold_asked;    // bumped by the stimulus to request a hold-off
    int hold_taken;    // bumped by the receiver once a hold-off is over

    i2c_master_controller_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_write_byte(s_write_byte), .s_device_address(s_device_address),
        .s_register_address(s_register_address), .s_sda_in(s_sda_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_scl_level(m_scl_level),
        .m_sda_level(m_sda_level), .m_ready_res(m_ready_res), .m_done_res(m_done_res),
        .m_read_data(m_read_data), .m_nack(m_nack),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    i2c_tick_checker #(.DELAY_ADDR(REG_DELAY)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_write_byte(s_write_byte), .s_device_address(s_device_address),
        .s_register_address(s_register_address), .s_sda_in(s_sda_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_scl_level(m_scl_level),
        .m_sda_level(m_sda_level), .m_ready_res(m_ready_res), .m_done_res(m_done_res),
        .m_read_data(m_read_data), .m_nack(m_nack),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off on request so the
    // queue inside the core fills and s_ready drops
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_taken != hold_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_taken++;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("i2c_master_controller_core_test: errors");
        $finish;
    end

    // one tick transaction; entered and left at a falling edge
    task automatic send_tick(logic [2:0] c, logic [7:0] wb, logic [7:0] dev,
                             logic [15:0] ra, logic sda);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= c;
        s_write_byte <= wb;
        s_device_address <= dev;
        s_register_address <= ra;
        s_sda_in <= sda;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // a command followed by filler ticks that carry a fixed sda level;
    // the filler command lands while the core is busy in most cases
    task automatic issue(logic [2:0] c, logic [7:0] wb, logic [7:0] dev, logic [15:0] ra,
                         logic sda, int fill, logic [2:0] fill_cmd);
        send_tick(c, wb, dev, ra, sda);
        repeat (fill) send_tick(fill_cmd, 8'($urandom), 8'($urandom), 16'($urandom), sda);
    endtask

    // random ticks: mostly empty ones so commands run to completion,
    // sda biased low so device acknowledges usually arrive
    task automatic random_ticks(int n);
        int r;
        logic [2:0] c;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 12) c = 3'($urandom_range(7));
            else if (r < 20) c = CMD_RANDOM_READ;
            else c = CMD_NONE;
            send_tick(c, 8'($urandom), 8'($urandom), 16'($urandom),
                      $urandom_range(99) < 30);
        end
    endtask

    // wait until every accepted tick has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] a, logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= a;
        pwdata <= d;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // reconfigure between transactions only, then read the register back
    task automatic set_delay(logic [15:0] v);
        drain();
        apb_access(1'b1, REG_DELAY, {16'd0, v});
        apb_access(1'b0, REG_DELAY, 32'd0);
        settings++;
    endtask

    task automatic set_mode(int idle_v, int stall_v);
        idle_pct = idle_v;
        stall_pct = stall_v;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_NONE;
        s_write_byte = 8'd0;
        s_device_address = 8'd0;
        s_register_address = 16'd0;
        s_sda_in = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        idle_pct = 0;
        stall_pct = 0;
        hold_asked = 0;
        hold_taken = 0;
        ticks_sent = 0;
        settings = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset delay of 250: unused code while idle, then a start with a
        // stop offered while busy, which the core must drop
        apb_access(1'b0, REG_DELAY, 32'd0);
        issue(UNUSED_CMD, 8'd0, 8'd0, 16'd0, 1'b0, 2, CMD_NONE);
        issue(CMD_START, 8'd0, 8'd0, 16'd0, 1'b0, 4, CMD_STOP);
        // stretch the running phase to the maximum, then cut it short with a
        // zero delay, which behaves as one tick per phase
        set_delay(16'hFFFF);
        issue(CMD_NONE, 8'd0, 8'd0, 16'd0, 1'b0, 6, CMD_NONE);
        set_delay(16'd0);
        issue(CMD_NONE, 8'd0, 8'd0, 16'd0, 1'b0, 6, CMD_NONE);

        // write with no acknowledge sets nack
        issue(CMD_WRITE, 8'hFF, 8'd0, 16'd0, 1'b1, 30, CMD_NONE);
        set_delay(16'd1);
        // write with acknowledge, a random read offered while busy
        issue(CMD_WRITE, 8'h00, 8'd0, 16'd0, 1'b0, 20, CMD_RANDOM_READ);
        issue(CMD_NONE, 8'd0, 8'd0, 16'd0, 1'b0, 10, CMD_NONE);
        // receive all ones with ack, all zeros with nack, then a stop
        issue(CMD_READ_ACK, 8'd0, 8'd0, 16'd0, 1'b1, 30, CMD_NONE);
        issue(CMD_READ_NACK, 8'd0, 8'd0, 16'd0, 1'b0, 30, CMD_NONE);
        issue(CMD_STOP, 8'd0, 8'd0, 16'd0, 1'b0, 8, CMD_NONE);
        // random read where the device never answers: aborted with a stop
        issue(CMD_RANDOM_READ, 8'hFF, 8'd0, 16'hFFFF, 1'b1, 45, CMD_NONE);
        // full random read with every acknowledge present
        issue(CMD_RANDOM_READ, 8'd0, 8'h00, 16'h0000, 1'b0, 160, CMD_NONE);

        // random traffic under several flow-control patterns
        set_delay(16'd1);
        set_mode(0, 0);
        random_ticks(25);

        set_delay(16'd2);
        set_mode(70, 0);
        random_ticks(20);

        set_delay(16'd1);
        set_mode(0, 70);
        hold_asked++;   // receiver holds off while ticks keep coming
        random_ticks(25);

        drain();
        apb_access(1'b1, REG_SPARE, $urandom);
        set_delay(16'd3);
        set_mode(18, 18);
        random_ticks(20);

        set_mode(0, 0);
        drain();
        repeat (10) @(negedge aclk);

        $display("run covered %0d ticks over %0d delay settings, %0d results compared",
                 ticks_sent, settings, compared);
        if (mismatches == 0) begin
            $display("i2c_master_controller_core_test: clean");
        end else begin
            $display("i2c_master_controller_core_test: errors");
        end
        $finish;
    end

endmodule
